[src/cfli_pkg.sv]
// ----------------------------------------------------------------------------
// Cube face leaf index package
// Widths shared by the divider lanes and the top level, plus the face codes
// and the sideband record used by the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cfli_pkg;

   localparam int QUO_W  = 31;   // quotient bits, one per divider stage
   localparam int DVD_W  = 63;   // dividend width
   localparam int DVS_W  = 33;   // divisor width
   localparam int REM_W  = 33;   // partial remainder width
   localparam int FRAC_W = 30;   // fraction bits of the Q1.30 coordinates

   localparam logic [2:0] FACE_PX = 3'd0;
   localparam logic [2:0] FACE_PY = 3'd1;
   localparam logic [2:0] FACE_PZ = 3'd2;
   localparam logic [2:0] FACE_NX = 3'd3;
   localparam logic [2:0] FACE_NY = 3'd4;
   localparam logic [2:0] FACE_NZ = 3'd5;

   typedef struct packed {
      logic [2:0] face;
      logic       invalid;
      logic       neg_u;
      logic       neg_v;
   } side_type;

endpackage

`default_nettype wire

[src/cfli_div_lane.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider lane
// One quotient bit per stage; the dividend is known to be below the divisor
// times 2^QUO_W. Stage enables come from the top-level valid/ready chain.
// ----------------------------------------------------------------------------
`default_nettype none

module cfli_div_lane
   import cfli_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [QUO_W:0]     en,
   input  wire logic [DVD_W-1:0]   dividend,
   input  wire logic [DVS_W-1:0]   divisor,
   output logic      [QUO_W-1:0]   quo,
   output logic      [REM_W-1:0]   rem,
   output logic      [DVS_W-1:0]   dvs
);

   logic [REM_W-1:0]   rem_ff [0:QUO_W];
   logic [QUO_W-1:0]   low_ff [0:QUO_W];
   logic [QUO_W-1:0]   quo_ff [0:QUO_W];
   logic [DVS_W-1:0]   dvs_ff [0:QUO_W];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= {1'b0, dividend[DVD_W-1:QUO_W]};
         low_ff[0] <= dividend[QUO_W-1:0];
         quo_ff[0] <= '0;
         dvs_ff[0] <= divisor;
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
      logic [REM_W:0]   trial;
      logic             ge;
      logic [REM_W:0]   diff;
      logic [REM_W-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
         ge     = trial >= {1'b0, dvs_ff[k-1]};
         diff   = trial - {1'b0, dvs_ff[k-1]};
         rem_in = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= {low_ff[k-1][QUO_W-2:0], 1'b0};
            quo_ff[k] <= {quo_ff[k-1][QUO_W-2:0], ge};
            dvs_ff[k] <= dvs_ff[k-1];
         end
      end
   end

   assign quo = quo_ff[QUO_W];
   assign rem = rem_ff[QUO_W];
   assign dvs = dvs_ff[QUO_W];

endmodule

`default_nettype wire

[src/cube_face_leaf_index_top.sv]
// ----------------------------------------------------------------------------
// Cube face leaf index
// Direction vector to cube face, Q1.30 face coordinates and leaf indices.
// ----------------------------------------------------------------------------
// Accepts one vector word per cycle unless an output stall has backed up to
// the first stage, and returns one result word per vector, in order.
// The pipeline is made of four parallel restoring dividers that resolve one
// quotient bit per stage (31 stages), plus a face selection stage, a dividend
// setup stage and a rounding/output stage. Each stage holds its word while
// the next one cannot take it, so empty stages close up during an output stall.
`default_nettype none

module cube_face_leaf_index_top
   import cfli_pkg::*;
#(
   parameter int LEVEL_BITS = 30
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_vec_x,
   input  wire logic signed [31:0] req_vec_y,
   input  wire logic signed [31:0] req_vec_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_face_index,
   output logic signed [31:0]      rsp_u_coord,
   output logic signed [31:0]      rsp_v_coord,
   output logic [29:0]             rsp_leaf_i,
   output logic [29:0]             rsp_leaf_j,
   output logic                    rsp_invalid
);

   localparam int NST = QUO_W + 3;   // stage count, last one is the output
   localparam logic [QUO_W:0] LEAF_MAX = (QUO_W+1)'((64'(1) << LEVEL_BITS) - 1);

   // ---------------- valid/ready chain ----------------
   logic [NST-1:0] vld_ff;
   logic [NST:0]   rdy;

   assign rdy[NST] = rsp_ready;
   for (genvar k = 0; k < NST; k++) begin : g_rdy
      assign rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NST-1];

   // ---------------- stage 0: face selection ----------------
   logic [31:0]        ax, ay, az;
   logic signed [32:0] xs, ys, zs, un, vn, dn;
   logic [2:0]         face;
   logic               comp_neg;

   always_comb begin
      xs = {req_vec_x[31], req_vec_x};
      ys = {req_vec_y[31], req_vec_y};
      zs = {req_vec_z[31], req_vec_z};
      ax = req_vec_x[31] ? 32'(-xs) : req_vec_x;
      ay = req_vec_y[31] ? 32'(-ys) : req_vec_y;
      az = req_vec_z[31] ? 32'(-zs) : req_vec_z;
      if (ax > ay) begin
         face     = (ax > az) ? FACE_PX : FACE_PZ;
         comp_neg = (ax > az) ? req_vec_x[31] : req_vec_z[31];
      end else begin
         face     = (ay > az) ? FACE_PY : FACE_PZ;
         comp_neg = (ay > az) ? req_vec_y[31] : req_vec_z[31];
      end
      if (comp_neg) begin
         face = face + 3'd3;
      end
      case (face)
         FACE_PX: begin un = ys;  vn = zs;  dn = xs; end
         FACE_PY: begin un = -xs; vn = zs;  dn = ys; end
         FACE_PZ: begin un = -xs; vn = -ys; dn = zs; end
         FACE_NX: begin un = zs;  vn = ys;  dn = xs; end
         FACE_NY: begin un = zs;  vn = -xs; dn = ys; end
         default: begin un = -ys; vn = -xs; dn = zs; end
      endcase
   end

   side_type           side_ff [0:NST-2];
   logic [31:0]        dmag_ff, umag_ff, vmag_ff;
   logic signed [32:0] nu_ff, nv_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         side_ff[0].face    <= face;
         side_ff[0].invalid <= (req_vec_x == 0) && (req_vec_y == 0) && (req_vec_z == 0);
         side_ff[0].neg_u   <= un[32] ^ dn[32];
         side_ff[0].neg_v   <= vn[32] ^ dn[32];
         dmag_ff            <= 32'(dn[32] ? -dn : dn);
         umag_ff            <= 32'(un[32] ? -un : un);
         vmag_ff            <= 32'(vn[32] ? -vn : vn);
         nu_ff              <= dn[32] ? -un : un;
         nv_ff              <= dn[32] ? -vn : vn;
      end
   end

   for (genvar k = 1; k < NST-1; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------- stage 1 inputs: dividends ----------------
   logic signed [33:0] sum_u, sum_v;
   logic [DVD_W-1:0]   dvd_u, dvd_v, dvd_i, dvd_j;

   always_comb begin
      sum_u = $signed({nu_ff[32], nu_ff}) + $signed({2'b00, dmag_ff});
      sum_v = $signed({nv_ff[32], nv_ff}) + $signed({2'b00, dmag_ff});
      dvd_u = DVD_W'(umag_ff) << FRAC_W;
      dvd_v = DVD_W'(vmag_ff) << FRAC_W;
      dvd_i = (DVD_W'(sum_u[32:0]) << LEVEL_BITS) + DVD_W'(dmag_ff);
      dvd_j = (DVD_W'(sum_v[32:0]) << LEVEL_BITS) + DVD_W'(dmag_ff);
   end

   logic [QUO_W-1:0] q_u, q_v, q_i, q_j;
   logic [REM_W-1:0] r_u, r_v, r_i, r_j;
   logic [DVS_W-1:0] s_u, s_v, s_i, s_j;

   cfli_div_lane u_lane_u (.clock, .en(rdy[QUO_W+1:1]), .dividend(dvd_u),
      .divisor({1'b0, dmag_ff}), .quo(q_u), .rem(r_u), .dvs(s_u));
   cfli_div_lane u_lane_v (.clock, .en(rdy[QUO_W+1:1]), .dividend(dvd_v),
      .divisor({1'b0, dmag_ff}), .quo(q_v), .rem(r_v), .dvs(s_v));
   cfli_div_lane u_lane_i (.clock, .en(rdy[QUO_W+1:1]), .dividend(dvd_i),
      .divisor({dmag_ff, 1'b0}), .quo(q_i), .rem(r_i), .dvs(s_i));
   cfli_div_lane u_lane_j (.clock, .en(rdy[QUO_W+1:1]), .dividend(dvd_j),
      .divisor({dmag_ff, 1'b0}), .quo(q_j), .rem(r_j), .dvs(s_j));

   // ---------------- final stage: sign, rounding, clamp ----------------
   function automatic logic [29:0] leaf_round(input logic [QUO_W-1:0] q,
                                              input logic [REM_W-1:0] r,
                                              input logic [DVS_W-1:0] d);
      logic           up;
      logic [QUO_W:0] lf;
      logic [QUO_W:0] res;
      // Quotient is floor(N*s + 1/2); round half to even, then drop the half.
      up  = ({r, 1'b0} > {1'b0, d}) || (({r, 1'b0} == {1'b0, d}) && !q[0]);
      lf  = {1'b0, q} + (QUO_W+1)'(up);
      res = (lf == '0) ? '0 : lf - 1'b1;
      if (res > LEAF_MAX) begin
         res = LEAF_MAX;
      end
      return res[29:0];
   endfunction

   side_type         sd;
   logic [2:0]       face_in;
   logic [31:0]      u_in, v_in;
   logic [29:0]      i_in, j_in;

   always_comb begin
      sd      = side_ff[NST-2];
      face_in = sd.face;
      u_in    = sd.neg_u ? -{1'b0, q_u} : {1'b0, q_u};
      v_in    = sd.neg_v ? -{1'b0, q_v} : {1'b0, q_v};
      i_in    = leaf_round(q_i, r_i, s_i);
      j_in    = leaf_round(q_j, r_j, s_j);
      if (sd.invalid) begin
         face_in = '0;
         u_in    = '0;
         v_in    = '0;
         i_in    = '0;
         j_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NST-1]) begin
         rsp_face_index <= face_in;
         rsp_u_coord    <= u_in;
         rsp_v_coord    <= v_in;
         rsp_leaf_i     <= i_in;
         rsp_leaf_j     <= j_in;
         rsp_invalid    <= sd.invalid;
      end
   end

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_face_index == 3'd0 && rsp_u_coord == 0
         && rsp_v_coord == 0 && rsp_leaf_i == 30'd0 && rsp_leaf_j == 30'd0)
      else $error("invalid word carries nonzero fields");
   a_leaf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_leaf_i} <= LEAF_MAX && {1'b0, rsp_leaf_j} <= LEAF_MAX)
      else $error("leaf index beyond level");
   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_u_coord <= 32'sh4000_0000 && rsp_u_coord >= -32'sh4000_0000
         && rsp_v_coord <= 32'sh4000_0000 && rsp_v_coord >= -32'sh4000_0000)
      else $error("face coordinate out of range");
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted word lost at first stage");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-2] && !side_ff[NST-2].invalid |-> r_u < s_u && r_v < s_v
         && r_i < s_i && r_j < s_j)
      else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// Cube face leaf index testbench
// Drives direction vectors with random gaps and output stalls, predicts face,
// Q1.30 coordinates and leaf indices for each word, and checks results in
// order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import cfli_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEAF_BITS = 30;

   typedef struct {
      logic [2:0]         face;
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic [29:0]        li;
      logic [29:0]        lj;
      logic               inv;
   } leaf_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_vec_x = '0;
   logic signed [31:0] req_vec_y = '0;
   logic signed [31:0] req_vec_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_face_index;
   logic signed [31:0] rsp_u_coord, rsp_v_coord;
   logic [29:0] rsp_leaf_i, rsp_leaf_j;
   logic rsp_invalid;

   leaf_result_type expected_leaves[$];
   int mismatch_count = 0;
   bit stall_heavy = 1'b0;
   int stall_left = 0;

   always #2 clock = ~clock;

   cube_face_leaf_index_top #(.LEVEL_BITS(LEAF_BITS)) u_top (.*);

   function automatic logic [31:0] q130_of(longint num, longint den);
      longint r;
      r = (num * (64'sd1 <<< 30)) / den;
      return r[31:0];
   endfunction

   function automatic logic [29:0] leaf_of(longint num, longint den);
      longint n, p, q, f, r;
      n = 64'sd1 <<< LEAF_BITS;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      p = n * (num + den) - den;
      q = 2 * den;
      p += q;
      f = p / q - 1;
      r = p % q;
      if (2 * r > q || (2 * r == q && f[0])) f++;
      if (f < 0) f = 0;
      if (f > n - 1) f = n - 1;
      return f[29:0];
   endfunction

   function automatic leaf_result_type project_vector(logic signed [31:0] xi,
                                                      logic signed [31:0] yi,
                                                      logic signed [31:0] zi);
      leaf_result_type res;
      longint x, y, z, ax, ay, az, un, vn, den, comp;
      logic [2:0] face;
      x = xi; y = yi; z = zi;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      res = '{face: '0, u: '0, v: '0, li: '0, lj: '0, inv: 1'b0};
      if (x == 0 && y == 0 && z == 0) begin
         res.inv = 1'b1;
         return res;
      end
      if (ax > ay) face = (ax > az) ? FACE_PX : FACE_PZ;
      else         face = (ay > az) ? FACE_PY : FACE_PZ;
      comp = (face == FACE_PX) ? x : (face == FACE_PY) ? y : z;
      if (comp < 0) face = face + 3'd3;
      case (face)
         FACE_PX: begin un = y;  vn = z;  den = x; end
         FACE_PY: begin un = -x; vn = z;  den = y; end
         FACE_PZ: begin un = -x; vn = -y; den = z; end
         FACE_NX: begin un = z;  vn = y;  den = x; end
         FACE_NY: begin un = z;  vn = -x; den = y; end
         default: begin un = -y; vn = -x; den = z; end
      endcase
      res.face = face;
      res.u = q130_of(un, den);
      res.v = q130_of(vn, den);
      res.li = leaf_of(un, den);
      res.lj = leaf_of(vn, den);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Valid stays high after acceptance only when the next word follows at
   // once; a gap drops it, and the caller drops it after the last word.
   task automatic send_vector(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      expected_leaves.push_back(project_vector(x, y, z));
      do @(posedge clock); while (!req_ready);
   endtask

   // Output stall: random, with occasional long holds.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
         stall_left <= $urandom_range(10, 40);
         rsp_ready <= 1'b0;
      end
      else if (stall_heavy) rsp_ready <= ($urandom_range(0, 99) < 15) ? 1'b0
                                         : ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 19) != 0);
   end

   always @(posedge clock) begin
      leaf_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_leaves.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = expected_leaves.pop_front();
            if (rsp_face_index !== want.face)
               report_mismatch("face", rsp_face_index, want.face);
            if (rsp_u_coord !== want.u) report_mismatch("u", rsp_u_coord, want.u);
            if (rsp_v_coord !== want.v) report_mismatch("v", rsp_v_coord, want.v);
            if (rsp_leaf_i !== want.li) report_mismatch("leaf_i", rsp_leaf_i, want.li);
            if (rsp_leaf_j !== want.lj) report_mismatch("leaf_j", rsp_leaf_j, want.lj);
            if (rsp_invalid !== want.inv)
               report_mismatch("invalid", rsp_invalid, want.inv);
         end
      end
   end

   function automatic logic signed [31:0] rand_component(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 20)) - 10;
         2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000001;
         default: return 32'sh80000000;
      endcase
   endfunction

   task automatic test_directed();
      logic signed [31:0] mx, mn;
      mx = 32'sh7FFFFFFF;
      mn = 32'sh80000000;
      send_vector(0, 0, 0);
      send_vector(1, 0, 0);
      send_vector(0, 1, 0);
      send_vector(0, 0, 1);
      send_vector(-1, 0, 0);
      send_vector(0, -1, 0);
      send_vector(0, 0, -1);
      send_vector(5, 5, 0);        // tie x/y goes to y
      send_vector(5, 0, -5);       // tie x/z goes to z
      send_vector(-7, -7, -7);
      send_vector(mx, mx, mx);
      send_vector(mn, mx, 0);
      send_vector(mn, mn, mn);
      send_vector(mx, mn, 3);
      send_vector(mn, 0, 0);
      send_vector(mx, -mx, 1);
      send_vector(3, 1, -1);
      send_vector(mx, 1, -1);
      send_vector(2, -1, 1);
      send_vector(mn, 1, -1);
      send_vector(0, 32'sh40000000, mn);
      send_vector(32'sh55555555, -32'sh2AAAAAAB, 32'sh12345678);
   endtask

   task automatic test_random(int count, bit heavy);
      stall_heavy = heavy;
      repeat (count) begin
         int mx, my, mz;
         mx = $urandom_range(0, 9); my = $urandom_range(0, 9); mz = $urandom_range(0, 9);
         send_vector(rand_component(mx < 6 ? 0 : mx < 8 ? 1 : mx < 9 ? 2 : 3),
                     rand_component(my < 6 ? 0 : my < 8 ? 1 : my < 9 ? 2 : 3),
                     rand_component(mz < 6 ? 0 : mz < 8 ? 1 : mz < 9 ? 2 : 3));
      end
   endtask

   task automatic test_back_to_back(int count);
      stall_heavy = 1'b0;
      req_valid <= 1'b1;
      repeat (count) begin
         logic signed [31:0] x, y, z;
         x = $urandom; y = $urandom; z = $urandom;
         req_vec_x <= x; req_vec_y <= y; req_vec_z <= z;
         expected_leaves.push_back(project_vector(x, y, z));
         do @(posedge clock); while (!req_ready);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(700, 1'b0);
      test_back_to_back(200);
      test_random(530, 1'b1);
      req_valid <= 1'b0;
      stall_heavy = 1'b0;
      while (expected_leaves.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
src/cfli_pkg.sv
src/cfli_div_lane.sv
src/cube_face_leaf_index_top.sv
test/tb.sv
